### sv/rcpdm_pkg.sv
// ----------------------------------------------------------------------------
// rcpdm_pkg
// Shared types and constants for the rc pulse differential drive mixer.
// ----------------------------------------------------------------------------
package rcpdm_pkg;

    localparam int PULSE_W           = 16;
    localparam int DUTY_W            = 8;
    localparam int AVERAGE_DEPTH_DEF = 5;

    // linear map 1000..2000 us onto -255..255
    localparam int PULSE_LO   = 1000;
    localparam int SCALE_NUM  = 510;
    localparam int SCALE_DEN  = 1000;
    localparam int DUTY_MAX   = 255;

    // signed speed / turn value after mapping
    localparam int SPEED_W    = PULSE_W + 1;
    // |avg - 1000| * 510 stays below 2**25
    localparam int MAG_W      = 25;
    localparam int NUM_W      = 9;

    // reciprocal of the mapping denominator, exact for numerators below 2**MAG_W
    localparam int          SCALE_SHIFT    = MAG_W + 10;
    localparam logic [63:0] SCALE_RCP_FULL =
        ((64'd1 << SCALE_SHIFT) + 64'(SCALE_DEN - 1)) / 64'(SCALE_DEN);
    localparam int          RCP_W          = MAG_W + 1;
    localparam logic [RCP_W-1:0] SCALE_RCP = SCALE_RCP_FULL[RCP_W-1:0];

    typedef struct packed {
        logic [PULSE_W-1:0] throttle_pulse_us;
        logic [PULSE_W-1:0] steering_pulse_us;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] left_forward_duty;
        logic [DUTY_W-1:0] left_reverse_duty;
        logic [DUTY_W-1:0] right_forward_duty;
        logic [DUTY_W-1:0] right_reverse_duty;
        logic              signal_ok;
    } t_out;

    // per-stage load strobes for the scaling pipeline
    typedef struct packed {
        logic mean;
        logic mag;
        logic rcp;
        logic value;
    } t_scale_en;

endpackage

### sv/rc_pulse_differential_drive_mixer_core.sv
// ----------------------------------------------------------------------------
// rc_pulse_differential_drive_mixer_core
// Moving-average filter of throttle and steering pulses, arcade drive mix.
//
//   channel   valid        ready        payload
//   input     i_in_valid   o_in_ready   i_in_data  (rcpdm_pkg::t_in)
//   output    o_out_valid  i_out_ready  o_out_data (rcpdm_pkg::t_out)
//
// one transaction per cycle while the output side is not stalled
// the history cells and the running sums update in the accepting cycle
// stages hand on when the next one is free, so bubbles close up under stall
// synchronous active-low reset clears the history, sums and stage valids
// ----------------------------------------------------------------------------
module rc_pulse_differential_drive_mixer_core #(
    parameter int AVERAGE_DEPTH = rcpdm_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rcpdm_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rcpdm_pkg::t_out  o_out_data
);

    localparam int SUM_W   = rcpdm_pkg::PULSE_W + $clog2(AVERAGE_DEPTH);
    localparam int PW      = rcpdm_pkg::PULSE_W;
    localparam int SW      = rcpdm_pkg::SPEED_W;
    localparam int MIX_W   = SW + 1;
    localparam int NSTAGE  = 6;

    logic [PW-1:0] w_thr [0:AVERAGE_DEPTH];
    logic [PW-1:0] w_str [0:AVERAGE_DEPTH];

    logic                 w_accept;
    logic [NSTAGE:1]      r_vld;
    logic [NSTAGE:1]      w_rdy;
    logic [NSTAGE-1:1]    r_ok;

    logic [SUM_W-1:0]     r_thr_sum;
    logic [SUM_W-1:0]     r_str_sum;
    logic [SUM_W-1:0]     n_thr_sum;
    logic [SUM_W-1:0]     n_str_sum;
    logic [SUM_W-1:0]     r_thr_s1;
    logic [SUM_W-1:0]     r_str_s1;

    rcpdm_pkg::t_scale_en w_scale_en;
    logic signed [SW-1:0] w_speed;
    logic signed [SW-1:0] w_turn;

    logic signed [MIX_W-1:0] w_left;
    logic signed [MIX_W-1:0] w_right;
    logic signed [MIX_W-1:0] w_left_c;
    logic signed [MIX_W-1:0] w_right_c;
    logic signed [MIX_W-1:0] w_left_n;
    logic signed [MIX_W-1:0] w_right_n;
    rcpdm_pkg::t_out         n_out;
    rcpdm_pkg::t_out         r_out;

    // row of history cells, newest sample in cell zero
    assign w_thr[0] = i_in_data.throttle_pulse_us;
    assign w_str[0] = i_in_data.steering_pulse_us;

    for (genvar g = 0; g < AVERAGE_DEPTH; g++) begin : g_cell
        rcpdm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_thr   (w_thr[g]),
            .i_str   (w_str[g]),
            .o_thr   (w_thr[g+1]),
            .o_str   (w_str[g+1])
        );
    end

    // stage handover: a stage loads when it is empty or its successor loads
    always_comb begin
        w_rdy[NSTAGE] = !r_vld[NSTAGE] || i_out_ready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_ready = w_rdy[1];
    assign w_accept   = i_in_valid && w_rdy[1];

    // window sum: add the newest sample, drop the one leaving the last cell
    assign n_thr_sum = r_thr_sum + SUM_W'(i_in_data.throttle_pulse_us)
                     - SUM_W'(w_thr[AVERAGE_DEPTH]);
    assign n_str_sum = r_str_sum + SUM_W'(i_in_data.steering_pulse_us)
                     - SUM_W'(w_str[AVERAGE_DEPTH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sum <= '0;
            r_str_sum <= '0;
            r_vld     <= '0;
        end else begin
            if (w_accept) begin
                r_thr_sum <= n_thr_sum;
                r_str_sum <= n_str_sum;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_thr_s1 <= n_thr_sum;
            r_str_s1 <= n_str_sum;
            r_ok[1]  <= (i_in_data.throttle_pulse_us != '0)
                     && (i_in_data.steering_pulse_us != '0);
        end
        for (int k = 2; k < NSTAGE; k++) begin
            if (w_rdy[k]) begin
                r_ok[k] <= r_ok[k-1];
            end
        end
    end

    assign w_scale_en.mean  = w_rdy[2];
    assign w_scale_en.mag   = w_rdy[3];
    assign w_scale_en.rcp   = w_rdy[4];
    assign w_scale_en.value = w_rdy[5];

    rcpdm_scale #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_scale_thr (
        .i_clk   (i_clk),
        .i_en    (w_scale_en),
        .i_sum   (r_thr_s1),
        .o_value (w_speed)
    );

    rcpdm_scale #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_scale_str (
        .i_clk   (i_clk),
        .i_en    (w_scale_en),
        .i_sum   (r_str_s1),
        .o_value (w_turn)
    );

    // arcade mix, clamp and split into bridge duties
    always_comb begin
        w_left  = MIX_W'(w_speed) - MIX_W'(w_turn);
        w_right = MIX_W'(w_speed) + MIX_W'(w_turn);

        if (w_left > MIX_W'(rcpdm_pkg::DUTY_MAX)) begin
            w_left_c = MIX_W'(rcpdm_pkg::DUTY_MAX);
        end else if (w_left < -MIX_W'(rcpdm_pkg::DUTY_MAX)) begin
            w_left_c = -MIX_W'(rcpdm_pkg::DUTY_MAX);
        end else begin
            w_left_c = w_left;
        end

        if (w_right > MIX_W'(rcpdm_pkg::DUTY_MAX)) begin
            w_right_c = MIX_W'(rcpdm_pkg::DUTY_MAX);
        end else if (w_right < -MIX_W'(rcpdm_pkg::DUTY_MAX)) begin
            w_right_c = -MIX_W'(rcpdm_pkg::DUTY_MAX);
        end else begin
            w_right_c = w_right;
        end

        w_left_n  = -w_left_c;
        w_right_n = -w_right_c;

        n_out = '0;
        if (r_ok[NSTAGE-1]) begin
            n_out.signal_ok = 1'b1;
            if (w_left_c[MIX_W-1]) begin
                n_out.left_reverse_duty = w_left_n[rcpdm_pkg::DUTY_W-1:0];
            end else begin
                n_out.left_forward_duty = w_left_c[rcpdm_pkg::DUTY_W-1:0];
            end
            if (w_right_c[MIX_W-1]) begin
                n_out.right_reverse_duty = w_right_n[rcpdm_pkg::DUTY_W-1:0];
            end else begin
                n_out.right_forward_duty = w_right_c[rcpdm_pkg::DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTAGE]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[NSTAGE];
    assign o_out_data  = r_out;

    // an empty first stage never holds off the input side
    a_in_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[1] |-> o_in_ready)
        else $error("input stalled with first stage empty");

    // a timed-out transaction carries no drive
    a_timeout_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.signal_ok) |->
            (o_out_data.left_forward_duty == '0) && (o_out_data.left_reverse_duty == '0)
            && (o_out_data.right_forward_duty == '0)
            && (o_out_data.right_reverse_duty == '0))
        else $error("duty present without valid signal");

    // never both sides of one bridge
    a_bridge_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.left_forward_duty == '0) || (o_out_data.left_reverse_duty == '0))
            && ((o_out_data.right_forward_duty == '0)
                || (o_out_data.right_reverse_duty == '0)))
        else $error("forward and reverse duty both driven");

    // the window sum moves only on an accepted transaction
    a_sum_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_accept && $past(i_rst_n)) |=> $stable(r_thr_sum) && $stable(r_str_sum))
        else $error("window sum changed without a transaction");

endmodule

### sv/rcpdm_cell.sv
// ----------------------------------------------------------------------------
// rcpdm_cell
// One history cell: holds a throttle and a steering sample and hands them on.
// ----------------------------------------------------------------------------
module rcpdm_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_shift,
    input  logic [rcpdm_pkg::PULSE_W-1:0]     i_thr,
    input  logic [rcpdm_pkg::PULSE_W-1:0]     i_str,
    output logic [rcpdm_pkg::PULSE_W-1:0]     o_thr,
    output logic [rcpdm_pkg::PULSE_W-1:0]     o_str
);

    logic [rcpdm_pkg::PULSE_W-1:0] r_thr;
    logic [rcpdm_pkg::PULSE_W-1:0] r_str;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_str <= '0;
        end else if (i_shift) begin
            r_thr <= i_thr;
            r_str <= i_str;
        end
    end

    assign o_thr = r_thr;
    assign o_str = r_str;

endmodule

### sv/rcpdm_scale.sv
// ----------------------------------------------------------------------------
// rcpdm_scale
// Window sum to mean, then mean mapped onto the signed drive range.
// ----------------------------------------------------------------------------
module rcpdm_scale #(
    parameter  int AVERAGE_DEPTH = rcpdm_pkg::AVERAGE_DEPTH_DEF,
    localparam int SUM_W         = rcpdm_pkg::PULSE_W + $clog2(AVERAGE_DEPTH)
) (
    input  logic                                   i_clk,
    input  rcpdm_pkg::t_scale_en                   i_en,
    input  logic [SUM_W-1:0]                       i_sum,
    output logic signed [rcpdm_pkg::SPEED_W-1:0]   o_value
);

    // reciprocal of the depth, exact for every sum below 2**SUM_W
    localparam int     DIV_SHIFT = SUM_W + 5;
    localparam longint DIV_RCP_L =
        ((longint'(1) << DIV_SHIFT) + longint'(AVERAGE_DEPTH) - 1) / longint'(AVERAGE_DEPTH);
    localparam logic [DIV_SHIFT:0] DIV_RCP = DIV_RCP_L[DIV_SHIFT:0];
    localparam int     PROD_W    = SUM_W + DIV_SHIFT + 1;
    localparam int     SPROD_W   = rcpdm_pkg::MAG_W + rcpdm_pkg::RCP_W;
    localparam int     PW        = rcpdm_pkg::PULSE_W;
    localparam int     SW        = rcpdm_pkg::SPEED_W;

    logic [PROD_W-1:0]             r_prod;
    logic                          r_neg;
    logic [rcpdm_pkg::MAG_W-1:0]   r_mag;
    logic                          r_neg_d;
    logic [SPROD_W-1:0]            r_sprod;
    logic signed [SW-1:0]          r_value;

    logic [PW-1:0]        w_avg;
    logic signed [SW-1:0] w_off;
    logic [PW-1:0]        w_abs;
    logic [PW-1:0]        w_quo;
    logic signed [SW-1:0] w_signed;

    always_comb begin
        w_avg = r_prod[DIV_SHIFT +: PW];
        w_off = $signed({1'b0, w_avg}) - SW'(rcpdm_pkg::PULSE_LO);
        w_abs = w_off[SW-1] ? PW'(-w_off) : w_off[PW-1:0];
        // truncation toward zero: divide the magnitude, restore the sign
        w_quo = r_sprod[rcpdm_pkg::SCALE_SHIFT +: PW];
        w_signed = r_neg_d ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mean) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(DIV_RCP);
        end
        if (i_en.mag) begin
            r_neg <= w_off[SW-1];
            r_mag <= rcpdm_pkg::MAG_W'(w_abs) * rcpdm_pkg::MAG_W'(rcpdm_pkg::SCALE_NUM);
        end
        if (i_en.rcp) begin
            r_neg_d <= r_neg;
            r_sprod <= SPROD_W'(r_mag) * SPROD_W'(rcpdm_pkg::SCALE_RCP);
        end
        if (i_en.value) begin
            r_value <= w_signed - SW'(rcpdm_pkg::DUTY_MAX);
        end
    end

    assign o_value = r_value;

endmodule
